@@ sv/command_frame_builder_crc16_assert.svh @@
// Assertion macros shared by the command frame builder RTL.
`ifndef COMMAND_FRAME_BUILDER_CRC16_ASSERT_SVH
`define COMMAND_FRAME_BUILDER_CRC16_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define CFBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfbc assertion failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define CFBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfbc assertion failed");

`endif

@@ sv/cfbc_pkg.sv @@
// Types, constants and the byte-wide CRC step of the command frame builder.
`default_nettype none
package cfbc_pkg;

  // Frame sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_HCRC_HI,
    ST_HCRC_LO,
    ST_DATA,
    ST_DCRC_HI,
    ST_DCRC_LO
  } state_t;

  localparam logic [7:0]  SOF_BYTE   = 8'hA5;
  localparam logic [7:0]  NODE_RESET = 8'h3F;
  localparam logic [7:0]  CTRL_DATA  = 8'h02;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'h0000;

  // Header byte positions.
  localparam logic [3:0] HDR_SOF   = 4'd0;
  localparam logic [3:0] HDR_NODE  = 4'd1;
  localparam logic [3:0] HDR_CTRL  = 4'd2;
  localparam logic [3:0] HDR_INDEX = 4'd3;
  localparam logic [3:0] HDR_OFS   = 4'd4;
  localparam logic [3:0] HDR_WORDS = 4'd5;

  // One byte through CRC-16/XMODEM, MSB first, no reflection.
  function automatic logic [15:0] crc_push(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/cfbc_if.sv @@
// Channel interfaces of the command frame builder: command, frame byte and configuration.
`default_nettype none

// Drive command channel.
interface cfbc_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  control_byte;
  logic [7:0]  register_index;
  logic [7:0]  register_offset;
  logic [2:0]  word_count;
  logic [63:0] payload_value;

  modport source (output valid, control_byte, register_index, register_offset,
                  word_count, payload_value, input ready);
  modport sink   (input valid, control_byte, register_index, register_offset,
                  word_count, payload_value, output ready);
endinterface

// Frame byte channel.
interface cfbc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, frame_byte, end_of_frame, input ready);
  modport sink   (input valid, frame_byte, end_of_frame, output ready);
endinterface

// Node address write channel.
interface cfbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] node_address;

  modport source (output valid, node_address, input ready);
  modport sink   (input valid, node_address, output ready);
endinterface

`default_nettype wire

@@ sv/command_frame_builder_crc16.sv @@
// Command frame builder: turns one drive command into a CRC-16 protected byte frame.
//
// Channels: cmd takes one drive command per item; frame delivers the frame one
// byte per item, with end_of_frame set on the last byte; cfg writes the node
// address byte (reset value 0x3F) and is always ready.
// Frame: 0xA5, node address, control, index, offset, word count, header CRC
// high and low; a command with control 2 adds 2*word_count payload bytes, low
// byte first, and a data CRC high and low. A command with a word count above
// MAX_WORDS is taken and dropped without output.
// Timing: cmd is ready only while the sequencer is idle. After acceptance the
// sequencer enters the header state, from which the first byte is loaded into
// the output register; then one byte per cycle follows while frame is not stalled,
// and the sequencer returns to idle after the last of its 8, or 10 to 18, bytes.
// One byte-wide CRC unit, shared by header and data, sets the one byte per
// cycle pace. A stall on frame holds the output register and the sequencer.
// Reset: synchronous, clears the sequencer, the output valid and restores the
// node address.
`default_nettype none
`include "command_frame_builder_crc16_assert.svh"

module command_frame_builder_crc16
  import cfbc_pkg::*;
#(
  parameter int MAX_WORDS = 4
) (
  input  wire         clk,
  input  wire         rst,
  cfbc_cmd_if.sink    cmd,
  cfbc_byte_if.source frame,
  cfbc_cfg_if.sink    cfg
);

  state_t      state, state_next;
  logic [3:0]  cnt, cnt_next;
  logic [15:0] crc, crc_next;
  logic [63:0] payload, payload_next;
  logic [7:0]  ctrl;
  logic [7:0]  idx;
  logic [7:0]  ofs;
  logic [2:0]  words;
  logic [7:0]  node_address;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        emit;
  logic        cmd_fire;
  logic        cmd_ok;
  logic [7:0]  cur_byte;
  logic        cur_last;
  logic [3:0]  nbytes;
  logic        is_data;

  // Handshake glue.
  assign cmd.ready          = (state == ST_IDLE);
  assign cfg.ready          = 1'b1;
  assign frame.valid        = out_valid;
  assign frame.frame_byte   = out_byte;
  assign frame.end_of_frame = out_last;

  assign cmd_fire = cmd.valid && cmd.ready;
  assign cmd_ok   = (cmd.word_count <= 3'(MAX_WORDS));
  assign emit     = (state != ST_IDLE) && (!out_valid || frame.ready);
  assign nbytes   = {words, 1'b0};
  assign is_data  = (ctrl == CTRL_DATA);

  // Node address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= NODE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      node_address <= cfg.node_address;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    crc     <= crc_next;
    payload <= payload_next;
    if (cmd_fire) begin
      ctrl  <= cmd.control_byte;
      idx   <= cmd.register_index;
      ofs   <= cmd.register_offset;
      words <= cmd.word_count;
    end
  end

  // Next state, frame byte selection and the shared CRC unit.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    crc_next     = crc;
    payload_next = payload;
    cur_byte     = 8'h00;
    cur_last     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_fire && cmd_ok) begin
          state_next   = ST_HDR;
          cnt_next     = 4'd0;
          crc_next     = CRC_INIT;
          payload_next = cmd.payload_value;
        end
      end
      ST_HDR: begin
        case (cnt)
          HDR_SOF:   cur_byte = SOF_BYTE;
          HDR_NODE:  cur_byte = node_address;
          HDR_CTRL:  cur_byte = ctrl;
          HDR_INDEX: cur_byte = idx;
          HDR_OFS:   cur_byte = ofs;
          HDR_WORDS: cur_byte = {5'b00000, words};
          default:   cur_byte = 8'h00;
        endcase
        if (emit) begin
          crc_next = crc_push(crc, cur_byte);
          cnt_next = cnt + 4'd1;
          if (cnt == HDR_WORDS) begin
            state_next = ST_HCRC_HI;
          end
        end
      end
      ST_HCRC_HI: begin
        cur_byte = crc[15:8];
        if (emit) begin
          state_next = ST_HCRC_LO;
        end
      end
      ST_HCRC_LO: begin
        cur_byte = crc[7:0];
        cur_last = !is_data;
        if (emit) begin
          cnt_next = 4'd0;
          crc_next = CRC_INIT;
          if (!is_data) begin
            state_next = ST_IDLE;
          end else if (words == 3'd0) begin
            state_next = ST_DCRC_HI;
          end else begin
            state_next = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        cur_byte = payload[7:0];
        if (emit) begin
          crc_next     = crc_push(crc, cur_byte);
          payload_next = {8'h00, payload[63:8]};
          cnt_next     = cnt + 4'd1;
          if (cnt == nbytes - 4'd1) begin
            state_next = ST_DCRC_HI;
          end
        end
      end
      ST_DCRC_HI: begin
        cur_byte = crc[15:8];
        if (emit) begin
          state_next = ST_DCRC_LO;
        end
      end
      ST_DCRC_LO: begin
        cur_byte = crc[7:0];
        cur_last = 1'b1;
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: loads a byte from the busy sequencer whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= cur_byte;
      out_last <= cur_last;
    end
  end

  // An oversized command is dropped and the sequencer stays idle.
  `CFBC_ASSERT_NEXT(a_drop_oversize, cmd_fire && !cmd_ok, state == ST_IDLE)
  // The final byte leaves the sequencer idle with the byte flagged in the output.
  `CFBC_ASSERT_NEXT(a_last_to_idle, emit && cur_last,
                    state == ST_IDLE && out_valid && out_last)
  // Data bytes are only sent for a data command with at least one word.
  `CFBC_ASSERT_NOW(a_data_legal, state == ST_DATA,
                   is_data && words != 3'd0 && cnt < nbytes)
  // The header counter never runs past the word count byte.
  `CFBC_ASSERT_NOW(a_hdr_range, state == ST_HDR, cnt <= HDR_WORDS)

endmodule
`default_nettype wire
